@@ src/pbfl_pkg.sv @@
// Shared types and constants of the packet buffer free list.
// Holds field widths, command, status and state codes, and the request and result records.
// Depends on nothing.
package pbfl_pkg;

  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int LEVEL_W       = 7;
  localparam int POOL_SIZE_DEF = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC_ONE = 2'd0,
    CMD_ALLOC_N   = 2'd1,
    CMD_FREE      = 2'd2,
    CMD_RESET     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_DFREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_BATCH
  } back_state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [CNT_W-1:0]   count;
    logic               cnt_zero;
    logic [IDX_W-1:0]   ret_index;
    logic               ret_ok;
  } req_t;

  typedef struct packed {
    logic   valid;
    req_t   req;
  } qhead_t;

  typedef struct packed {
    logic [IDX_W-1:0]   given_index;
    logic               has_buffer;
    status_t            status;
    logic [LEVEL_W-1:0] free_count;
    logic               last;
  } result_t;

endpackage

@@ src/pbfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the free stack. Depends on nothing.
module pbfl_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/pbfl_front.sv @@
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
// Depends on pbfl_pkg.
module pbfl_front #(
  parameter int POOL_SIZE = pbfl_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [pbfl_pkg::CNT_W-1:0]   in_count,
  input  logic [pbfl_pkg::IDX_W-1:0]   in_return_index,
  output pbfl_pkg::qhead_t             head,
  input  logic                         pop
);

  pbfl_pkg::req_t req_in;
  pbfl_pkg::req_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           push;

  // Decode the request; flag indices outside the pool here.
  always_comb begin
    req_in.cmd       = pbfl_pkg::cmd_t'(in_cmd);
    req_in.count     = in_count;
    req_in.cnt_zero  = (in_count == '0);
    req_in.ret_index = in_return_index;
    req_in.ret_ok    = (pbfl_pkg::LEVEL_W'(in_return_index) < pbfl_pkg::LEVEL_W'(POOL_SIZE));
  end

  assign in_stall   = fill_r[1];
  assign push       = in_valid && !in_stall;
  assign head.valid = (fill_r != 2'd0);
  assign head.req   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

@@ src/pbfl_back.sv @@
// Back end: owns the free stack, stack level and borrowed marks, executes one request
// at a time and drives the result register. Depends on pbfl_pkg and pbfl_ram.
module pbfl_back #(
  parameter int POOL_SIZE = pbfl_pkg::POOL_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pbfl_pkg::qhead_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pbfl_pkg::result_t   res
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int IW = pbfl_pkg::IDX_W;
  localparam int LW = pbfl_pkg::LEVEL_W;
  localparam int CW = pbfl_pkg::CNT_W;
  localparam logic [LW-1:0] FULL_LEVEL = LW'(POOL_SIZE);

  pbfl_pkg::back_state_t state_r, state_nxt;
  pbfl_pkg::req_t        cur_r, cur_nxt;
  pbfl_pkg::result_t     res_r, res_nxt;
  logic [LW-1:0]         level_r, level_nxt;
  logic [POOL_SIZE-1:0]  borrowed_r, borrowed_nxt;
  logic [POOL_SIZE-1:0]  filled_r, filled_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [AW-1:0]         addr_r, rd_addr;
  logic                  rd_fill_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ready;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [IW-1:0]         wdata;
  logic [IW-1:0]         rdata;
  logic [IW-1:0]         stack_idx;
  logic [LW-1:0]         base;
  logic                  short_n;
  logic                  batch_more;

  pbfl_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // An entry not written since the last refill holds its own address.
  assign stack_idx  = rd_fill_r ? rdata : IW'(addr_r);
  assign out_ready  = !out_valid_r || !out_stall;
  assign base       = level_r - LW'(cur_r.count);
  assign short_n    = (LW'(cur_r.count) > level_r);
  assign batch_more = (cur_r.cmd == pbfl_pkg::CMD_ALLOC_N) && !short_n && !cur_r.cnt_zero
                      && (cur_r.count != CW'(1));
  assign out_valid  = out_valid_r;
  assign res        = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbfl_pkg::BK_IDLE: begin
        if (head.valid) state_nxt = pbfl_pkg::BK_EXEC;
      end
      pbfl_pkg::BK_EXEC: begin
        if (out_ready) state_nxt = batch_more ? pbfl_pkg::BK_BATCH : pbfl_pkg::BK_IDLE;
      end
      pbfl_pkg::BK_BATCH: begin
        if (out_ready && rem_r == CW'(1)) state_nxt = pbfl_pkg::BK_IDLE;
      end
      default: state_nxt = pbfl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    cur_nxt       = cur_r;
    level_nxt     = level_r;
    borrowed_nxt  = borrowed_r;
    filled_nxt    = filled_r;
    rem_nxt       = rem_r;
    rd_addr       = addr_r;
    we            = 1'b0;
    waddr         = AW'(level_r);
    wdata         = cur_r.ret_index;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    unique case (state_r)
      pbfl_pkg::BK_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          cur_nxt = head.req;
          // Start the stack read for the top entry or the bottom of the group.
          if (head.req.cmd == pbfl_pkg::CMD_ALLOC_N) begin
            rd_addr = AW'(level_r - LW'(head.req.count));
          end else begin
            rd_addr = AW'(level_r - LW'(1));
          end
        end
      end
      pbfl_pkg::BK_EXEC: begin
        if (out_ready) begin
          out_valid_nxt       = 1'b1;
          res_nxt.given_index = '0;
          res_nxt.has_buffer  = 1'b0;
          res_nxt.status      = pbfl_pkg::STAT_OK;
          res_nxt.free_count  = level_r;
          res_nxt.last        = 1'b1;
          unique case (cur_r.cmd)
            pbfl_pkg::CMD_ALLOC_ONE: begin
              if (level_r == '0) begin
                res_nxt.status = pbfl_pkg::STAT_SHORT;
              end else begin
                res_nxt.given_index = stack_idx;
                res_nxt.has_buffer  = 1'b1;
                res_nxt.free_count  = level_r - LW'(1);
                level_nxt           = level_r - LW'(1);
                borrowed_nxt[stack_idx[AW-1:0]] = 1'b1;
              end
            end
            pbfl_pkg::CMD_ALLOC_N: begin
              if (short_n) begin
                res_nxt.status = pbfl_pkg::STAT_SHORT;
              end else if (!cur_r.cnt_zero) begin
                res_nxt.given_index = stack_idx;
                res_nxt.has_buffer  = 1'b1;
                res_nxt.free_count  = base;
                res_nxt.last        = !batch_more;
                level_nxt           = base;
                rem_nxt             = cur_r.count - CW'(1);
                borrowed_nxt[stack_idx[AW-1:0]] = 1'b1;
                if (batch_more) rd_addr = addr_r + AW'(1);
              end
            end
            pbfl_pkg::CMD_FREE: begin
              if (!cur_r.ret_ok || !borrowed_r[cur_r.ret_index[AW-1:0]]) begin
                res_nxt.status = pbfl_pkg::STAT_DFREE;
              end else begin
                borrowed_nxt[cur_r.ret_index[AW-1:0]] = 1'b0;
                if (level_r < FULL_LEVEL) begin
                  we                         = 1'b1;
                  filled_nxt[AW'(level_r)]   = 1'b1;
                  level_nxt                  = level_r + LW'(1);
                  res_nxt.free_count         = level_r + LW'(1);
                end
              end
            end
            pbfl_pkg::CMD_RESET: begin
              borrowed_nxt       = '0;
              filled_nxt         = '0;
              level_nxt          = FULL_LEVEL;
              res_nxt.free_count = FULL_LEVEL;
            end
            default: res_nxt.status = pbfl_pkg::STAT_OK;
          endcase
        end
      end
      pbfl_pkg::BK_BATCH: begin
        if (out_ready) begin
          out_valid_nxt       = 1'b1;
          res_nxt.given_index = stack_idx;
          res_nxt.has_buffer  = 1'b1;
          res_nxt.status      = pbfl_pkg::STAT_OK;
          res_nxt.free_count  = level_r;
          res_nxt.last        = (rem_r == CW'(1));
          rem_nxt             = rem_r - CW'(1);
          borrowed_nxt[stack_idx[AW-1:0]] = 1'b1;
          if (rem_r != CW'(1)) rd_addr = addr_r + AW'(1);
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbfl_pkg::BK_IDLE;
      level_r     <= FULL_LEVEL;
      borrowed_r  <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      borrowed_r  <= borrowed_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    res_r     <= res_nxt;
    rem_r     <= rem_nxt;
    addr_r    <= rd_addr;
    rd_fill_r <= filled_r[rd_addr];
  end

endmodule

@@ src/packet_buffer_free_list_core.sv @@
// Packet buffer free list: a pool of POOL_SIZE buffer indices on a LIFO free stack with a
// borrowed mark per buffer. Requests carry cmd 0 allocate one, 1 allocate count buffers,
// 2 free return_index, 3 refill the pool; every result reports the free count. A single
// allocate, free or refill passes the execution unit as queue pop with stack read, then
// execute and load the result register. An allocate n that hands out count buffers emits
// one index per cycle while the consumer does not stall, bottom of the group first, last set
// on the final one; an allocate n with count zero or too few free buffers gives one result.
// Refill takes effect at once through per-entry fill marks, so there is no clearing pass after
// reset. A two-entry request queue decouples the input from execution, and the result
// register lets the next request start while a result waits for the consumer.
module packet_buffer_free_list_core #(
  parameter int POOL_SIZE = pbfl_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [pbfl_pkg::CNT_W-1:0]   in_count,
  input  logic [pbfl_pkg::IDX_W-1:0]   in_return_index,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pbfl_pkg::IDX_W-1:0]   out_given_index,
  output logic                         out_has_buffer,
  output logic [1:0]                   out_status,
  output logic [pbfl_pkg::LEVEL_W-1:0] out_free_count,
  output logic                         out_last
);

  pbfl_pkg::qhead_t  head;
  pbfl_pkg::result_t res;
  logic              pop;

  // Accept, decode and queue requests.
  pbfl_front #(.POOL_SIZE(POOL_SIZE)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_count        (in_count),
    .in_return_index (in_return_index),
    .head            (head),
    .pop             (pop)
  );

  // Execute against the stack and hold each result until taken.
  pbfl_back #(.POOL_SIZE(POOL_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Split the result record onto the ports.
  assign out_given_index = res.given_index;
  assign out_has_buffer  = res.has_buffer;
  assign out_status      = res.status;
  assign out_free_count  = res.free_count;
  assign out_last        = res.last;

endmodule

@@ src/pbfl_chk.sv @@
// Port-level checker for the packet buffer free list, bound to the top level.
// Depends on pbfl_pkg and packet_buffer_free_list_core.
module pbfl_chk #(
  parameter int POOL_SIZE = pbfl_pkg::POOL_SIZE_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pbfl_pkg::IDX_W-1:0]   out_given_index,
  input logic                         out_has_buffer,
  input logic [1:0]                   out_status,
  input logic [pbfl_pkg::LEVEL_W-1:0] out_free_count,
  input logic                         out_last
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_given_index) && $stable(out_last)
      && $stable(out_status) && $stable(out_free_count) && $stable(out_has_buffer))
    else $error("stalled result changed");

  // A handed-out buffer always comes with an ok status.
  a_buf_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_buffer |-> out_status == pbfl_pkg::STAT_OK)
    else $error("buffer given with error status");

  // No buffer means index zero and last set.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_buffer |-> out_given_index == '0 && out_last)
    else $error("index or last wrong without buffer");

  // Free count never exceeds the pool.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_count <= pbfl_pkg::LEVEL_W'(POOL_SIZE))
    else $error("free count beyond pool size");

  // Within a batch the free count stays constant.
  a_batch_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last ##1 out_valid |-> $stable(out_free_count))
    else $error("free count changed within a batch");

endmodule

bind packet_buffer_free_list_core pbfl_chk #(.POOL_SIZE(POOL_SIZE)) u_pbfl_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_given_index (out_given_index),
  .out_has_buffer  (out_has_buffer),
  .out_status      (out_status),
  .out_free_count  (out_free_count),
  .out_last        (out_last)
);

@@ tb/packet_buffer_free_list_core_tb.sv @@
// Self-checking testbench for packet_buffer_free_list_core: directed table, then random requests.
// Predicts every result from its own copy of the free stack and borrowed marks.
// Depends on pbfl_pkg and the packet_buffer_free_list_core RTL.
module packet_buffer_free_list_core_tb;
  import pbfl_pkg::*;

  localparam int POOL            = POOL_SIZE_DEF;
  localparam int RANDOM_REQUESTS = 406;
  localparam int IDLE_PCT        = 18;
  // Worst case: every request of the run handing out a whole pool while the consumer stalls.
  localparam int CYCLE_LIMIT     = 400000;
  // Idle time after the last awaited result, before the run ends.
  localparam int DRAIN_CYCLES    = 80;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic [CNT_W-1:0]   in_count;
  logic [IDX_W-1:0]   in_return_index;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [IDX_W-1:0]   out_given_index;
  logic               out_has_buffer;
  logic [1:0]         out_status;
  logic [LEVEL_W-1:0] out_free_count;
  logic               out_last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  packet_buffer_free_list_core #(
    .POOL_SIZE(POOL)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_count        (in_count),
    .in_return_index (in_return_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_given_index (out_given_index),
    .out_has_buffer  (out_has_buffer),
    .out_status      (out_status),
    .out_free_count  (out_free_count),
    .out_last        (out_last)
  );

  // Shadow copy of the pool: LIFO of free indices plus one borrowed mark per buffer.
  logic [IDX_W-1:0]   pool_stack [POOL];
  logic [LEVEL_W-1:0] pool_level;
  logic [POOL-1:0]    pool_borrowed;

  // Results owed by the block, oldest first.
  result_t awaited_results [$];

  int errors = 0;
  int cycles = 0;
  // Set during a stretch of the random part: neither side idles or stalls then.
  bit calm = 1'b0;

  typedef struct {
    cmd_t             cmd;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] ret;
    bit               typed;
    result_t          want;
  } step_t;

  step_t directed_steps [$];

  function automatic result_t make_result(int idx, int has, status_t st, int level, int fin);
    result_t r;
    r.given_index = idx[IDX_W-1:0];
    r.has_buffer  = has[0];
    r.status      = st;
    r.free_count  = level[LEVEL_W-1:0];
    r.last        = fin[0];
    return r;
  endfunction

  // Append one result to the tail of the owed list.
  task automatic owe_result(result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_stack[i] = i[IDX_W-1:0];
    end
    pool_borrowed = '0;
    pool_level    = POOL[LEVEL_W-1:0];
  endtask

  // Apply one accepted request to the shadow pool and queue the results it owes.
  task automatic model_pool_command(cmd_t cmd, logic [CNT_W-1:0] cnt, logic [IDX_W-1:0] ret);
    int base;
    int idx;
    case (cmd)
      CMD_ALLOC_ONE: begin
        if (pool_level == 0) begin
          owe_result(make_result(0, 0, STAT_SHORT, 0, 1));
        end else begin
          pool_level = pool_level - LEVEL_W'(1);
          idx = int'(pool_stack[pool_level]);
          pool_borrowed[idx] = 1'b1;
          owe_result(make_result(idx, 1, STAT_OK, pool_level, 1));
        end
      end
      CMD_ALLOC_N: begin
        if (cnt > pool_level) begin
          owe_result(make_result(0, 0, STAT_SHORT, pool_level, 1));
        end else if (cnt == 0) begin
          owe_result(make_result(0, 0, STAT_OK, pool_level, 1));
        end else begin
          // Bottom of the group first; every result carries the level after the whole group.
          base = int'(pool_level) - int'(cnt);
          for (int k = 0; k < cnt; k++) begin
            idx = int'(pool_stack[base + k]);
            pool_borrowed[idx] = 1'b1;
            owe_result(make_result(idx, 1, STAT_OK, base, (k + 1 == cnt)));
          end
          pool_level = base[LEVEL_W-1:0];
        end
      end
      CMD_FREE: begin
        // An index outside the pool is never borrowed, so it counts as a double free.
        if (ret >= POOL || !pool_borrowed[ret]) begin
          owe_result(make_result(0, 0, STAT_DFREE, pool_level, 1));
        end else begin
          pool_borrowed[ret] = 1'b0;
          // Drop the push on a full stack.
          if (pool_level < POOL) begin
            pool_stack[pool_level] = ret;
            pool_level = pool_level + LEVEL_W'(1);
          end
          owe_result(make_result(0, 0, STAT_OK, pool_level, 1));
        end
      end
      default: begin
        refill_pool();
        owe_result(make_result(0, 0, STAT_OK, pool_level, 1));
      end
    endcase
  endtask

  task automatic add_step(cmd_t cmd, int count, int ret, bit typed,
                          int gidx, int has, status_t st, int level);
    step_t s;
    s.cmd   = cmd;
    s.count = count[CNT_W-1:0];
    s.ret   = ret[IDX_W-1:0];
    s.typed = typed;
    s.want  = make_result(gidx, has, st, level, 1);
    directed_steps.insert(directed_steps.size(), s);
  endtask

  task automatic note_mismatch(string msg);
    errors++;
    $display("[%0d] MISMATCH %s", cycles, msg);
  endtask

  // Offer one request, idling first at random, and hold it until the block takes it.
  task automatic send_request(cmd_t cmd, logic [CNT_W-1:0] cnt, logic [IDX_W-1:0] ret,
                              bit typed, result_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_count        <= cnt;
    in_return_index <= ret;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_pool_command(cmd, cnt, ret);
    // Rows with a known single answer check against the typed value instead.
    if (typed) begin
      awaited_results[awaited_results.size() - 1] = want;
    end
  endtask

  // Result side: check each accepted result, then pick the next stall at random.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    got = result_t'({out_given_index, out_has_buffer, out_status, out_free_count, out_last});
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result idx=%0d has=%0d st=%0d free=%0d last=%0d",
                                got.given_index, got.has_buffer, got.status,
                                got.free_count, got.last));
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          note_mismatch($sformatf(
            "idx %0d/%0d has %0d/%0d st %0d/%0d free %0d/%0d last %0d/%0d (got/exp)",
            got.given_index, want.given_index, got.has_buffer, want.has_buffer,
            got.status, want.status, got.free_count, want.free_count,
            got.last, want.last));
        end
      end
    end
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cmd_t             cmd;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] ret;
    int               roll;
    int               start;
    result_t          none;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = CMD_ALLOC_ONE;
    in_count        = '0;
    in_return_index = '0;
    none            = '0;
    refill_pool();

    // Directed rows: cmd, count, return index, typed?, then index, has, status, free count.
    add_step(CMD_ALLOC_ONE, 0,   0,  1, 63, 1, STAT_OK,    63); // top of a fresh pool
    add_step(CMD_FREE,      0,   63, 1, 0,  0, STAT_OK,    64);
    add_step(CMD_FREE,      0,   63, 1, 0,  0, STAT_DFREE, 64); // double free
    add_step(CMD_ALLOC_N,   0,   17, 1, 0,  0, STAT_OK,    64); // count zero
    add_step(CMD_ALLOC_N,   65,  0,  1, 0,  0, STAT_SHORT, 64); // one too many
    add_step(CMD_ALLOC_N,   127, 63, 1, 0,  0, STAT_SHORT, 64); // widest count
    add_step(CMD_ALLOC_N,   64,  0,  0, 0,  0, STAT_OK,    0);  // drain the whole pool
    add_step(CMD_ALLOC_ONE, 127, 63, 1, 0,  0, STAT_SHORT, 0);  // empty stack
    add_step(CMD_ALLOC_N,   1,   0,  1, 0,  0, STAT_SHORT, 0);
    add_step(CMD_ALLOC_N,   0,   0,  1, 0,  0, STAT_OK,    0);
    add_step(CMD_FREE,      0,   0,  1, 0,  0, STAT_OK,    1);
    add_step(CMD_FREE,      5,   5,  0, 0,  0, STAT_OK,    0);
    add_step(CMD_ALLOC_ONE, 0,   0,  0, 0,  0, STAT_OK,    0);
    add_step(CMD_FREE,      127, 63, 0, 0,  0, STAT_OK,    0);
    add_step(CMD_ALLOC_N,   2,   0,  0, 0,  0, STAT_OK,    0);
    add_step(CMD_RESET,     0,   0,  1, 0,  0, STAT_OK,    64);
    add_step(CMD_FREE,      0,   0,  1, 0,  0, STAT_DFREE, 64); // nothing borrowed after refill
    add_step(CMD_ALLOC_N,   3,   42, 0, 0,  0, STAT_OK,    0);
    add_step(CMD_FREE,      0,   62, 0, 0,  0, STAT_OK,    0);
    add_step(CMD_ALLOC_ONE, 0,   0,  0, 0,  0, STAT_OK,    0);
    add_step(CMD_ALLOC_N,   61,  0,  0, 0,  0, STAT_OK,    0);
    add_step(CMD_FREE,      64,  21, 0, 0,  0, STAT_OK,    0);
    add_step(CMD_RESET,     127, 63, 1, 0,  0, STAT_OK,    64);
    add_step(CMD_ALLOC_ONE, 127, 42, 1, 63, 1, STAT_OK,    63);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      send_request(directed_steps[i].cmd, directed_steps[i].count, directed_steps[i].ret,
                   directed_steps[i].typed, directed_steps[i].want);
    end

    // Random part: mostly legal alloc/free traffic, some short and double-free requests, rare refills.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm <= (n >= 180 && n < 260);
      roll = $urandom_range(99);
      cnt  = CNT_W'($urandom);
      ret  = IDX_W'($urandom);
      if (roll < 30) begin
        cmd = CMD_ALLOC_ONE;
      end else if (roll < 50) begin
        cmd  = CMD_ALLOC_N;
        roll = $urandom_range(99);
        if (roll < 70) begin
          cnt = CNT_W'($urandom_range(6));
        end else if (roll < 82) begin
          cnt = pool_level;
        end else if (roll < 92) begin
          cnt = CNT_W'($urandom_range(POOL));
        end else begin
          cnt = CNT_W'($urandom_range(127, pool_level + 1));
        end
      end else if (roll < 96) begin
        cmd = CMD_FREE;
        // Hand back a borrowed buffer most of the time; keep the random index otherwise.
        if ($urandom_range(99) < 85 && pool_borrowed != '0) begin
          start = $urandom_range(POOL - 1);
          for (int k = 0; k < POOL; k++) begin
            if (pool_borrowed[(start + k) % POOL]) begin
              ret = IDX_W'((start + k) % POOL);
              break;
            end
          end
        end
      end else begin
        cmd = CMD_RESET;
      end
      send_request(cmd, cnt, ret, 1'b0, none);
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/pbfl_pkg.sv
src/pbfl_ram.sv
src/pbfl_front.sv
src/pbfl_back.sv
src/packet_buffer_free_list_core.sv
src/pbfl_chk.sv
tb/packet_buffer_free_list_core_tb.sv
